// ===== rtl/mkd_pkg.sv =====
// Package for the Morse keyer decoder: register codes, reset values,
// shared structs and the Morse character table. No dependencies.
package mkd_pkg;

	localparam int DEF_COUNT_WIDTH = 16;
	localparam int CFG_WIDTH       = 16;
	localparam int CHAR_WIDTH      = 7;
	localparam int REG_IDX_WIDTH   = 2;
	localparam int SYM_CNT_WIDTH   = 3;
	localparam int SYM_BITS_WIDTH  = 5;

	localparam logic [SYM_CNT_WIDTH-1:0] MAX_SYMBOLS = 3'd5;
	localparam logic [SYM_CNT_WIDTH-1:0] TOO_LONG    = 3'd6;

	localparam logic [CFG_WIDTH-1:0] RST_DOT_MIN   = 16'd1875;
	localparam logic [CFG_WIDTH-1:0] RST_DOT_MAX   = 16'd12500;
	localparam logic [CFG_WIDTH-1:0] RST_DASH_MAX  = 16'd25000;
	localparam logic [CFG_WIDTH-1:0] RST_GAP_TICKS = 16'd25000;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_DOT_MIN   = 2'd0,
		REG_DOT_MAX   = 2'd1,
		REG_DASH_MAX  = 2'd2,
		REG_GAP_TICKS = 2'd3
	} mkd_reg_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] dot_min;
		logic [CFG_WIDTH-1:0] dot_max;
		logic [CFG_WIDTH-1:0] dash_max;
		logic [CFG_WIDTH-1:0] gap_ticks;
	} mkd_cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [CHAR_WIDTH-1:0] character;
	} mkd_emit_t;

	// Symbol count and dot/dash pattern (first symbol in bit 0, 1 = dash)
	// to ASCII. Zero means the sequence is not a known character.
	function automatic logic [CHAR_WIDTH-1:0] morse_lookup(
		input logic [SYM_CNT_WIDTH-1:0]  cnt,
		input logic [SYM_BITS_WIDTH-1:0] bits
	);
		logic [CHAR_WIDTH-1:0] code;
		unique case ({cnt, bits})
			{3'd2, 5'd2}:  code = 7'h41;
			{3'd4, 5'd1}:  code = 7'h42;
			{3'd4, 5'd5}:  code = 7'h43;
			{3'd3, 5'd1}:  code = 7'h44;
			{3'd1, 5'd0}:  code = 7'h45;
			{3'd4, 5'd4}:  code = 7'h46;
			{3'd3, 5'd3}:  code = 7'h47;
			{3'd4, 5'd0}:  code = 7'h48;
			{3'd2, 5'd0}:  code = 7'h49;
			{3'd4, 5'd14}: code = 7'h4A;
			{3'd3, 5'd5}:  code = 7'h4B;
			{3'd4, 5'd2}:  code = 7'h4C;
			{3'd2, 5'd3}:  code = 7'h4D;
			{3'd2, 5'd1}:  code = 7'h4E;
			{3'd3, 5'd7}:  code = 7'h4F;
			{3'd4, 5'd6}:  code = 7'h50;
			{3'd4, 5'd11}: code = 7'h51;
			{3'd3, 5'd2}:  code = 7'h52;
			{3'd3, 5'd0}:  code = 7'h53;
			{3'd1, 5'd1}:  code = 7'h54;
			{3'd3, 5'd4}:  code = 7'h55;
			{3'd4, 5'd8}:  code = 7'h56;
			{3'd3, 5'd6}:  code = 7'h57;
			{3'd4, 5'd9}:  code = 7'h58;
			{3'd4, 5'd13}: code = 7'h59;
			{3'd4, 5'd3}:  code = 7'h5A;
			{3'd5, 5'd30}: code = 7'h31;
			{3'd5, 5'd28}: code = 7'h32;
			{3'd5, 5'd24}: code = 7'h33;
			{3'd5, 5'd16}: code = 7'h34;
			{3'd5, 5'd0}:  code = 7'h35;
			{3'd5, 5'd1}:  code = 7'h36;
			{3'd5, 5'd3}:  code = 7'h37;
			{3'd5, 5'd7}:  code = 7'h38;
			{3'd5, 5'd15}: code = 7'h39;
			{3'd5, 5'd31}: code = 7'h30;
			default:       code = '0;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/mkd_if.sv =====
// Channel interfaces of the Morse keyer decoder: key ticks, decoded
// characters and register writes. Depends on mkd_pkg.
interface mkd_key_if;
	logic valid;
	logic ready;
	logic pressed;
	modport source (output valid, output pressed, input ready);
	modport sink   (input valid, input pressed, output ready);
endinterface

interface mkd_char_if import mkd_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CHAR_WIDTH-1:0] character;
	modport source (output valid, output character, input ready);
	modport sink   (input valid, input character, output ready);
endinterface

interface mkd_cfg_if import mkd_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic [REG_IDX_WIDTH-1:0] index;
	logic [CFG_WIDTH-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mkd_core.sv =====
// Tick-by-tick decoder state: press and gap counters, symbol sequence and
// the character lookup. Depends on mkd_pkg.
module mkd_core import mkd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      pressed,
	input  mkd_cfg_t  cfg,
	output mkd_emit_t emit
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic                      prev_q;
	logic [COUNT_WIDTH-1:0]    press_q;
	logic [COUNT_WIDTH-1:0]    gap_q;
	logic                      armed_q;
	logic [SYM_CNT_WIDTH-1:0]  sym_cnt_q;
	logic [SYM_BITS_WIDTH-1:0] sym_bits_q;

	logic                      prev_d;
	logic [COUNT_WIDTH-1:0]    press_d;
	logic [COUNT_WIDTH-1:0]    gap_d;
	logic                      armed_d;
	logic [SYM_CNT_WIDTH-1:0]  sym_cnt_d;
	logic [SYM_BITS_WIDTH-1:0] sym_bits_d;

	logic [COUNT_WIDTH-1:0]    press_inc;
	logic [COUNT_WIDTH-1:0]    gap_inc;
	logic [CMP_W-1:0]          press_x;
	logic                      is_dot;
	logic                      is_dash;
	logic [CHAR_WIDTH-1:0]     code;

	assign press_inc = (press_q == CNT_MAX) ? CNT_MAX : press_q + CNT_ONE;
	assign gap_inc   = (gap_q == CNT_MAX) ? CNT_MAX : gap_q + CNT_ONE;
	assign press_x   = CMP_W'(press_q);

	// A saturated press is never a symbol.
	assign is_dot  = (press_q != CNT_MAX) && (press_x >= CMP_W'(cfg.dot_min))
		&& (press_x <= CMP_W'(cfg.dot_max));
	assign is_dash = (press_q != CNT_MAX) && (press_x > CMP_W'(cfg.dot_max))
		&& (press_x <= CMP_W'(cfg.dash_max));

	assign code = morse_lookup(sym_cnt_q, sym_bits_q);

	always_comb begin
		prev_d         = pressed;
		press_d        = press_q;
		gap_d          = gap_q;
		armed_d        = armed_q;
		sym_cnt_d      = sym_cnt_q;
		sym_bits_d     = sym_bits_q;
		emit.valid     = 1'b0;
		emit.character = code;
		priority if (pressed && !prev_q) begin
			press_d = CNT_ONE;
			armed_d = 1'b0;
			gap_d   = '0;
		end else if (pressed) begin
			press_d = press_inc;
		end else if (prev_q) begin
			armed_d = 1'b1;
			gap_d   = '0;
			if (is_dot || is_dash) begin
				if (sym_cnt_q < MAX_SYMBOLS) begin
					sym_bits_d[sym_cnt_q] = is_dash;
					sym_cnt_d = sym_cnt_q + 3'd1;
				end else begin
					sym_cnt_d = TOO_LONG;
				end
			end else begin
				sym_cnt_d  = '0;
				sym_bits_d = '0;
			end
		end else if (armed_q) begin
			gap_d = gap_inc;
			if (CMP_W'(gap_inc) >= CMP_W'(cfg.gap_ticks)) begin
				emit.valid = (code != '0);
				sym_cnt_d  = '0;
				sym_bits_d = '0;
				armed_d    = 1'b0;
				gap_d      = '0;
			end
		end else begin
			// Key released with no gap running: the state holds.
			gap_d = gap_q;
		end
		if (!step) begin
			emit.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 1'b0;
			press_q    <= '0;
			gap_q      <= '0;
			armed_q    <= 1'b0;
			sym_cnt_q  <= '0;
			sym_bits_q <= '0;
		end else if (step) begin
			prev_q     <= prev_d;
			press_q    <= press_d;
			gap_q      <= gap_d;
			armed_q    <= armed_d;
			sym_cnt_q  <= sym_cnt_d;
			sym_bits_q <= sym_bits_d;
		end
	end

endmodule

// ===== rtl/morse_keyer_decoder_unit.sv =====
// Top level of the Morse keyer decoder: register file, input stage and
// output register around mkd_core. Depends on mkd_pkg, mkd_if.sv, mkd_core.
//
// Usage. The key channel carries one beat per timer tick, holding the key
// level in pressed (1 = key held down). The chr channel carries one beat per
// decoded letter or digit, holding its ASCII code in character. Most ticks
// produce no beat; a character appears on the tick where the released gap
// after the last press reaches gap_ticks and the symbol sequence is known.
// The cfg channel writes the four timing registers (index 0 dot_min,
// 1 dot_max, 2 dash_max, 3 gap_ticks); it is always ready and a write takes
// effect at the edge where the beat is taken. Write only while the key
// channel is quiet and no character is pending.
//
// Pipeline: a key beat is registered in the input stage at acceptance, and
// the decode of the tick that completes a character is registered into the
// output register when the stage advances. One tick is taken every cycle;
// the only thing that limits this is the single-entry output register.
// When the receiver stalls, the pending character holds in the output
// register and one further tick may wait in the input stage; key ready then
// drops until the character is taken. Reset (arst_n low) restores the
// register defaults and clears the press, gap and symbol state.
module morse_keyer_decoder_unit import mkd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	mkd_key_if.sink    key,
	mkd_char_if.source chr,
	mkd_cfg_if.sink    cfg
);

	mkd_cfg_t              cfg_q;
	logic                  valid_s1;
	logic                  pressed_s1;
	logic                  chr_valid_q;
	logic [CHAR_WIDTH-1:0] chr_char_q;
	logic                  advance;
	mkd_emit_t             emit;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_min   <= RST_DOT_MIN;
			cfg_q.dot_max   <= RST_DOT_MAX;
			cfg_q.dash_max  <= RST_DASH_MAX;
			cfg_q.gap_ticks <= RST_GAP_TICKS;
		end else if (cfg.valid) begin
			unique case (mkd_reg_t'(cfg.index))
				REG_DOT_MIN:   cfg_q.dot_min   <= cfg.data;
				REG_DOT_MAX:   cfg_q.dot_max   <= cfg.data;
				REG_DASH_MAX:  cfg_q.dash_max  <= cfg.data;
				REG_GAP_TICKS: cfg_q.gap_ticks <= cfg.data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// The input stage moves on whenever the output register is free or is
	// being emptied this cycle.
	assign advance   = !chr_valid_q || chr.ready;
	assign key.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.ready && key.valid) begin
			pressed_s1 <= key.pressed;
		end
	end

	mkd_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.pressed (pressed_s1),
		.cfg     (cfg_q),
		.emit    (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_q <= 1'b0;
		end else if (advance) begin
			chr_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit.valid) begin
			chr_char_q <= emit.character;
		end
	end

	assign chr.valid     = chr_valid_q;
	assign chr.character = chr_char_q;

endmodule

// ===== rtl/mkd_checker.sv =====
// Port-level checks for the Morse keyer decoder and the bind that attaches
// them to morse_keyer_decoder_unit. Depends on mkd_pkg.
module mkd_checker import mkd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  key_valid,
	input logic                  key_ready,
	input logic                  chr_valid,
	input logic                  chr_ready,
	input logic [CHAR_WIDTH-1:0] chr_character,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	// A held character keeps its value until it is taken.
	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_ready |=> chr_valid && $stable(chr_character))
		else $error("character beat changed while stalled");

	// A new character follows directly from the tick that passed through the input stage just before it.
	a_chr_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(chr_valid) |-> $past(key_valid && key_ready, 2))
		else $error("character beat without a preceding tick");

	// Ticks are only held off while a character is pending.
	a_key_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!chr_valid |-> key_ready)
		else $error("tick refused with an empty output register");

	// Only digits and capital letters are ever decoded.
	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid |-> (chr_character >= 7'h30 && chr_character <= 7'h39)
			|| (chr_character >= 7'h41 && chr_character <= 7'h5A))
		else $error("character outside the decode table");

	// Register writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind morse_keyer_decoder_unit mkd_checker u_mkd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.key_valid     (key.valid),
	.key_ready     (key.ready),
	.chr_valid     (chr.valid),
	.chr_ready     (chr.ready),
	.chr_character (chr.character),
	.cfg_valid     (cfg.valid),
	.cfg_ready     (cfg.ready)
);
